// ===== rtl/cwt_pkg.sv =====
package cwt_pkg;

  localparam int unsigned PosBits   = 20;
  localparam int unsigned DepthBits = 8;
  localparam int unsigned TokPosW   = 20;
  localparam int unsigned TokLvlW   = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 64;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic signed [DepthBits-1:0] DepthMax = {1'b0, {(DepthBits-1){1'b1}}};
  localparam logic signed [DepthBits-1:0] DepthMin = {1'b1, {(DepthBits-1){1'b0}}};

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChDigLo  = 8'h30;
  localparam logic [7:0] ChDigHi  = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChUpLo   = 8'h41;
  localparam logic [7:0] ChUpHi   = 8'h5A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChLoLo   = 8'h61;
  localparam logic [7:0] ChLoHi   = 8'h7A;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;

  typedef struct packed {
    logic word;
    logic nul;
    logic lf;
    logic cr;
    logic slash;
    logic star;
    logic lbrace;
    logic rbrace;
    logic lparen;
    logic rparen;
    logic eq;
    logic semi;
  } cls_t;

  typedef struct packed {
    logic                      token_valid;
    logic [TokPosW-1:0]        token_start;
    logic [TokPosW-1:0]        token_end;
    logic signed [TokLvlW-1:0] brace_level;
    logic signed [TokLvlW-1:0] paren_level;
    logic                      saw_semicolon;
    logic                      saw_equals;
    logic                      end_of_text;
  } tok_t;

endpackage

// ===== rtl/cwt_char_class.sv =====
module cwt_char_class
  import cwt_pkg::*;
(
  input  logic [7:0] char_i,
  output cls_t       cls_o
);

  always_comb begin
    cls_o.word   = char_i inside {ChUnder, [ChDigLo:ChDigHi], [ChUpLo:ChUpHi], [ChLoLo:ChLoHi]};
    cls_o.nul    = (char_i == ChNul);
    cls_o.lf     = (char_i == ChLf);
    cls_o.cr     = (char_i == ChCr);
    cls_o.slash  = (char_i == ChSlash);
    cls_o.star   = (char_i == ChStar);
    cls_o.lbrace = (char_i == ChLBrace);
    cls_o.rbrace = (char_i == ChRBrace);
    cls_o.lparen = (char_i == ChLParen);
    cls_o.rparen = (char_i == ChRParen);
    cls_o.eq     = (char_i == ChEq);
    cls_o.semi   = (char_i == ChSemi);
  end

endmodule

// ===== rtl/cwt_lexer_core.sv =====
module cwt_lexer_core
  import cwt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic step_i,
  input  cls_t cls_i,
  output logic emit_o,
  output tok_t tok_o
);

  typedef enum logic [1:0] {CmNone, CmLine, CmBlock} cmode_e;

  logic                        strip_q;
  logic [PosBits-1:0]          pos_q, pos_d;
  logic                        in_word_q, in_word_d;
  logic [PosBits-1:0]          wstart_q, wstart_d;
  logic signed [DepthBits-1:0] brace_q, brace_d;
  logic signed [DepthBits-1:0] paren_q, paren_d;
  logic                        semi_q, semi_d;
  logic                        eq_q, eq_d;
  cmode_e                      cm_q, cm_d;
  logic                        star_q, star_d;
  logic                        slash_q, slash_d;
  logic                        skiplf_q, skiplf_d;

  cmode_e cm_eff;
  logic   star_eff, slash_eff, skiplf_eff;

  always_comb begin
    cm_eff     = strip_q ? cm_q : CmNone;
    star_eff   = strip_q & star_q;
    slash_eff  = strip_q & slash_q;
    skiplf_eff = strip_q & skiplf_q;

    pos_d    = pos_q;
    in_word_d = in_word_q;
    wstart_d = wstart_q;
    brace_d  = brace_q;
    paren_d  = paren_q;
    semi_d   = semi_q;
    eq_d     = eq_q;
    cm_d     = cm_eff;
    star_d   = star_eff;
    slash_d  = slash_eff;
    skiplf_d = 1'b0;
    emit_o   = 1'b0;

    tok_o.token_valid   = in_word_q;
    tok_o.token_start   = TokPosW'(wstart_q);
    tok_o.token_end     = TokPosW'(pos_q);
    tok_o.brace_level   = TokLvlW'(brace_q);
    tok_o.paren_level   = TokLvlW'(paren_q);
    tok_o.saw_semicolon = semi_q;
    tok_o.saw_equals    = eq_q;
    tok_o.end_of_text   = cls_i.nul;

    if (cls_i.nul) begin
      emit_o = 1'b1;
      if (!in_word_q) begin
        tok_o.token_start = '0;
        tok_o.token_end   = '0;
      end
      pos_d     = '0;
      in_word_d = 1'b0;
      wstart_d  = '0;
      brace_d   = '0;
      paren_d   = '0;
      semi_d    = 1'b0;
      eq_d      = 1'b0;
      cm_d      = CmNone;
      star_d    = 1'b0;
      slash_d   = 1'b0;
    end else begin
      if (pos_q != PosMax) pos_d = pos_q + 1'b1;
      if (skiplf_eff && cls_i.lf) begin
        // LF after a CR that closed a line comment is dropped
      end else if (cm_eff == CmLine) begin
        if (cls_i.lf || cls_i.cr) begin
          cm_d     = CmNone;
          skiplf_d = cls_i.cr;
        end
      end else if (cm_eff == CmBlock) begin
        if (star_eff && cls_i.slash) begin
          cm_d   = CmNone;
          star_d = 1'b0;
        end else begin
          star_d = cls_i.star;
        end
      end else begin
        slash_d = 1'b0;
        if (slash_eff && cls_i.slash) begin
          cm_d = CmLine;
        end else if (slash_eff && cls_i.star) begin
          cm_d   = CmBlock;
          star_d = 1'b1;
        end else if (cls_i.word) begin
          if (!in_word_q) begin
            in_word_d = 1'b1;
            wstart_d  = pos_q;
          end
        end else begin
          if (in_word_q) begin
            emit_o    = 1'b1;
            in_word_d = 1'b0;
            semi_d    = 1'b0;
            eq_d      = 1'b0;
          end
          if (cls_i.lbrace && brace_q != DepthMax) brace_d = brace_q + 1'b1;
          if (cls_i.rbrace && brace_q != DepthMin) brace_d = brace_q - 1'b1;
          if (cls_i.lparen && paren_q != DepthMax) paren_d = paren_q + 1'b1;
          if (cls_i.rparen && paren_q != DepthMin) paren_d = paren_q - 1'b1;
          if (cls_i.eq) eq_d = 1'b1;
          if (cls_i.semi) semi_d = 1'b1;
          slash_d = strip_q & cls_i.slash;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q   <= 1'b1;
      pos_q     <= '0;
      in_word_q <= 1'b0;
      wstart_q  <= '0;
      brace_q   <= '0;
      paren_q   <= '0;
      semi_q    <= 1'b0;
      eq_q      <= 1'b0;
      cm_q      <= CmNone;
      star_q    <= 1'b0;
      slash_q   <= 1'b0;
      skiplf_q  <= 1'b0;
    end else begin
      if (cfg_we_i) strip_q <= cfg_wdata_i;
      if (step_i) begin
        pos_q     <= pos_d;
        in_word_q <= in_word_d;
        wstart_q  <= wstart_d;
        brace_q   <= brace_d;
        paren_q   <= paren_d;
        semi_q    <= semi_d;
        eq_q      <= eq_d;
        cm_q      <= cm_d;
        star_q    <= star_d;
        slash_q   <= slash_d;
        skiplf_q  <= skiplf_d;
      end
    end
  end

endmodule

// ===== rtl/cwt_out_buf.sv =====
module cwt_out_buf
  import cwt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t tok_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output tok_t tok_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push_i && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/c_style_word_tokenizer.sv =====
// Streaming word tokenizer for C-style text: one byte per beat, one byte accepted every cycle
// while the output buffer is not full. A byte enters an input register, the lexer state and
// the result are updated in a single pass, and a result beat is written to the output buffer.
// Results wait in a two-beat output buffer, so input keeps flowing while the output is
// briefly stalled; when that buffer is full the input stalls. A zero byte always yields one
// beat with tlast set and clears all text state. cfg_wdata_i selects comment stripping
// (reset 1); the user sets it only while no text is in flight; the block does not enforce it.
module c_style_word_tokenizer
  import cwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] char_code
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [19:0] token_start, [39:20] token_end,
                                              // [47:40] brace_level, [55:48] paren_level,
                                              // [56] saw_semicolon, [57] saw_equals
  output logic                m_axis_tlast,   // end_of_text
  output logic                m_axis_tuser    // [0] token_valid
);

  logic               in_valid_q;
  logic [InDataW-1:0] in_byte_q;
  logic               buf_full;
  logic               step;
  logic               emit;
  cls_t               cls;
  tok_t               tok_res, tok_out;

  assign step          = in_valid_q && !buf_full;
  assign s_axis_tready = !in_valid_q || !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) in_valid_q <= 1'b1;
      else if (step) in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  cwt_char_class u_cls (
    .char_i (in_byte_q),
    .cls_o  (cls)
  );

  cwt_lexer_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .cls_i       (cls),
    .emit_o      (emit),
    .tok_o       (tok_res)
  );

  cwt_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && emit),
    .tok_i   (tok_res),
    .full_o  (buf_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok_out)
  );

  assign m_axis_tdata = {
    (OutDataW - 2 - 2*TokLvlW - 2*TokPosW)'(0),
    tok_out.saw_equals,
    tok_out.saw_semicolon,
    tok_out.paren_level,
    tok_out.brace_level,
    tok_out.token_end,
    tok_out.token_start
  };
  assign m_axis_tlast = tok_out.end_of_text;
  assign m_axis_tuser = tok_out.token_valid;

`ifndef SYNTH
  a_nul_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cls.nul) |-> emit)
    else $error("zero byte gave no result");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit) |=> m_axis_tvalid)
    else $error("result not presented after push");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (tok_out.token_end >= tok_out.token_start))
    else $error("word ends before it starts");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled byte lost");
`endif

endmodule
